[rtl/core/asm_expression_normalizer_top_defines.svh]
// Assertion macros shared by the expression normaliser RTL.
`ifndef ASM_EXPRESSION_NORMALIZER_TOP_DEFINES_SVH
`define ASM_EXPRESSION_NORMALIZER_TOP_DEFINES_SVH

// Checked on every rising edge of clk, and switched off while arst_n is low.
`define ANM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including the edges during reset.
`define ANM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/asm_norm_pkg.sv]
`default_nettype none

package asm_norm_pkg;

	// One input request: a byte of expression text.
	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_t;

	// One result request: a byte of the normalised text.
	typedef struct packed {
		logic [7:0] out_char;
		logic       out_run_last;
		logic       out_expr_end;
	} out_t;

	// Scan mode, one-hot.
	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_HELD0  = 5'b00010,
		MODE_IDENT  = 5'b00100,
		MODE_HEX    = 5'b01000,
		MODE_BIN    = 5'b10000
	} mode_t;

	// Everything that one input request decodes to.
	typedef struct packed {
		mode_t      mode;
		logic [1:0] count;
		out_t       item0;
		out_t       item1;
	} dec_t;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? (c & ~CASE_BIT) : c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/asm_norm_decode.sv]
`default_nettype none

module asm_norm_decode (
	input  wire asm_norm_pkg::mode_t mode,
	input  wire asm_norm_pkg::in_t   item,
	output asm_norm_pkg::dec_t       dec
);
	import asm_norm_pkg::*;

	logic [7:0] c;
	logic       last;
	logic       cls_emit;
	logic [7:0] cls_char;
	mode_t      cls_mode;
	logic [1:0] n;
	logic [7:0] ch0;
	logic [7:0] ch1;
	mode_t      nmode;

	assign c    = item.in_char;
	assign last = item.in_last;

	// Classification of a byte as it would be seen in the normal mode.
	always_comb begin
		cls_emit = 1'b1;
		cls_char = c;
		cls_mode = MODE_NORMAL;
		if (is_alpha(c) || c == CH_UNDER || c == CH_DOT) begin
			cls_char = to_upper(c);
			cls_mode = MODE_IDENT;
		end else if (c == CH_DOLLAR) begin
			cls_mode = MODE_HEX;
		end else if (c == CH_PERCENT) begin
			cls_mode = MODE_BIN;
		end else if (c == CH_ZERO && !last) begin
			cls_emit = 1'b0;
			cls_mode = MODE_HELD0;
		end
	end

	always_comb begin
		n     = {1'b0, cls_emit};
		ch0   = cls_char;
		ch1   = cls_char;
		nmode = cls_mode;
		case (mode)
			MODE_HELD0: begin
				ch0 = CH_ZERO;
				if ((c | CASE_BIT) == CH_LOWER_X) begin
					n     = 2'd2;
					ch1   = CH_LOWER_X;
					nmode = MODE_HEX;
				end else if ((c | CASE_BIT) == CH_LOWER_B) begin
					n     = 2'd2;
					ch1   = CH_LOWER_B;
					nmode = MODE_BIN;
				end else begin
					n = cls_emit ? 2'd2 : 2'd1;
				end
			end
			MODE_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DOT) begin
					n     = 2'd1;
					ch0   = to_upper(c);
					nmode = MODE_IDENT;
				end
			end
			MODE_HEX: begin
				if (is_hex(c)) begin
					n     = 2'd1;
					ch0   = to_upper(c);
					nmode = MODE_HEX;
				end
			end
			MODE_BIN: begin
				if (c == CH_ZERO || c == CH_ONE) begin
					n     = 2'd1;
					ch0   = c;
					nmode = MODE_BIN;
				end
			end
			default: begin
			end
		endcase
		// Each expression starts afresh in the normal mode.
		if (last) begin
			nmode = MODE_NORMAL;
		end
	end

	always_comb begin
		dec.mode               = nmode;
		dec.count              = n;
		dec.item0.out_char     = ch0;
		dec.item0.out_run_last = (n == 2'd1);
		dec.item0.out_expr_end = (n == 2'd1) && last;
		dec.item1.out_char     = ch1;
		dec.item1.out_run_last = 1'b1;
		dec.item1.out_expr_end = last;
	end

endmodule

`default_nettype wire

[rtl/core/asm_expression_normalizer_top.sv]
`default_nettype none

// Assembler expression normaliser. Expression text enters one byte per request on the text
// channel, with text_data.in_last set on the final byte, and the normalised bytes leave on the
// norm channel. Identifiers are uppercased, hex literals ('$' or '0x') keep a lower-case 'x'
// and have their digits uppercased, binary literals ('%' or '0b') keep a lower-case 'b', and
// every other byte passes through unchanged. A '0' seen outside a literal is held back for one
// byte of lookahead, so an input byte may give no result, one, or two (the held '0' and the
// byte itself); the last byte of an expression always gives at least one result. An accepted
// byte waits in an input register, where the decode logic classifies it against the current
// scan mode, and its results land in a two-entry output buffer that feeds the norm channel.
// The block takes one byte per cycle while each byte gives one result and norm_stall stays
// low; a byte that gives two results holds the input off until the output buffer has handed
// over its first result, and a held '0' gives no result for its byte. The rate is set by the
// output buffer, which hands over one result per cycle while norm_stall is low.

`include "asm_expression_normalizer_top_defines.svh"

module asm_expression_normalizer_top (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic text_valid,
	output                     logic text_stall,
	input  wire asm_norm_pkg::in_t   text_data,
	output                     logic norm_valid,
	input  wire                logic norm_stall,
	output asm_norm_pkg::out_t       norm_data
);
	import asm_norm_pkg::*;

	// Input register: the byte being decoded this cycle.
	logic       valid_s1;
	in_t        item_s1;

	// Scan mode left behind by the previous byte.
	mode_t      mode_q;

	// Output buffer: up to two results, slot0 is the one on offer.
	out_t       slot0_q;
	out_t       slot1_q;
	logic [1:0] cnt_q;

	dec_t       dec;
	logic       text_take;
	logic       norm_take;
	logic       consume;

	asm_norm_decode u_decode (
		.mode (mode_q),
		.item (item_s1),
		.dec  (dec)
	);

	// The buffered byte is decoded only when the output buffer will be empty at this edge,
	// so that both of its possible results fit.
	assign norm_take  = (cnt_q != 2'd0) && !norm_stall;
	assign consume    = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && norm_take));
	assign text_stall = valid_s1 && !consume;
	assign text_take  = text_valid && !text_stall;

	assign norm_valid = (cnt_q != 2'd0);
	assign norm_data  = slot0_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (consume || !valid_s1) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			item_s1 <= text_data;
		end
	end

	// Scan mode advances once per decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (consume) begin
			mode_q <= dec.mode;
		end
	end

	// Output buffer fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (consume) begin
			cnt_q <= dec.count;
		end else if (norm_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Output buffer contents: a fresh decode overwrites both slots, a take moves slot1 up.
	always_ff @(posedge clk) begin
		if (consume) begin
			slot0_q <= dec.item0;
			slot1_q <= dec.item1;
		end else if (norm_take) begin
			slot0_q <= slot1_q;
		end
	end

	`ANM_ASSERT(a_cnt_range, cnt_q != 2'd3, "output buffer holds more than two results")
	`ANM_ASSERT(a_stall_needs_byte, text_stall |-> valid_s1,
		"input stalled with an empty input register")
	`ANM_ASSERT(a_last_resets_mode, (consume && item_s1.in_last) |=> (mode_q == MODE_NORMAL),
		"scan mode not back to normal after the last byte of an expression")
	`ANM_ASSERT(a_pair_order, (cnt_q == 2'd2) |-> (!slot0_q.out_run_last && slot1_q.out_run_last),
		"result pair does not end on its second entry")
	`ANM_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (cnt_q == 2'd0 || !$past(arst_n)),
		"output buffer not empty after reset")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import asm_norm_pkg::*;

	// One request waiting for the driver. When hold_for_drain is set, the driver keeps
	// text_valid low until every expected normalised byte has come back.
	typedef struct {
		in_t req;
		bit  hold_for_drain;
	} text_entry_t;

	localparam logic [7:0] CH_UPPER_X = CH_LOWER_X ^ CASE_BIT;
	localparam logic [7:0] CH_UPPER_B = CH_LOWER_B ^ CASE_BIT;
	localparam int RANDOM_REQUESTS = 1400;
	localparam int MAX_WAIT = 5;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_PRINTED_ERRORS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	in_t text_data = '0;
	logic norm_valid;
	logic norm_stall = 1'b0;
	out_t norm_data;

	text_entry_t pending_text[$];
	out_t expected_norm[$];
	logic [7:0] step_bytes[$];
	logic [7:0] expr_buf[$];
	mode_t scan_state = MODE_NORMAL;
	int error_count = 0;

	asm_expression_normalizer_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_data(text_data),
		.norm_valid(norm_valid),
		.norm_stall(norm_stall),
		.norm_data(norm_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The run is cut off here if the block stops handing back results. The slowest correct
	// run needs well under a tenth of this.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED_ERRORS)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Character classes, ASCII only. Folding the case bit makes one range test cover both cases.
	function automatic bit letter_char(input logic [7:0] c);
		logic [7:0] folded;
		folded = c | CASE_BIT;
		return (c[7] == 1'b0) && (folded >= "a") && (folded <= "z");
	endfunction

	function automatic bit decimal_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= "9");
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return letter_char(c) || decimal_char(c) || (c == CH_UNDER) || (c == CH_DOT);
	endfunction

	function automatic bit hex_char(input logic [7:0] c);
		logic [7:0] folded;
		folded = c | CASE_BIT;
		return decimal_char(c) || ((folded >= "a") && (folded <= "f") && (c[7] == 1'b0));
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) ? c - CASE_BIT : c;
	endfunction

	// A byte seen outside any scan: it may open an identifier or a literal, or be a '0' that is
	// held back for lookahead unless it closes the expression.
	task automatic classify_plain(input logic [7:0] c, input bit last);
		if (letter_char(c) || c == CH_UNDER || c == CH_DOT) begin
			step_bytes.push_back(upcase(c));
			scan_state = MODE_IDENT;
		end else if (c == CH_DOLLAR) begin
			step_bytes.push_back(c);
			scan_state = MODE_HEX;
		end else if (c == CH_PERCENT) begin
			step_bytes.push_back(c);
			scan_state = MODE_BIN;
		end else if (c == CH_ZERO && !last) begin
			scan_state = MODE_HELD0;
		end else begin
			step_bytes.push_back(c);
			scan_state = MODE_NORMAL;
		end
	endtask

	// Works out the normalised bytes that one accepted request gives and queues them.
	task automatic predict_request(input in_t req);
		logic [7:0] c;
		out_t res;
		c = req.in_char;
		step_bytes.delete();
		case (scan_state)
			MODE_HELD0: begin
				step_bytes.push_back(CH_ZERO);
				if ((c | CASE_BIT) == CH_LOWER_X) begin
					step_bytes.push_back(CH_LOWER_X);
					scan_state = MODE_HEX;
				end else if ((c | CASE_BIT) == CH_LOWER_B) begin
					step_bytes.push_back(CH_LOWER_B);
					scan_state = MODE_BIN;
				end else begin
					classify_plain(c, req.in_last);
				end
			end
			MODE_IDENT: begin
				if (word_char(c))
					step_bytes.push_back(upcase(c));
				else
					classify_plain(c, req.in_last);
			end
			MODE_HEX: begin
				if (hex_char(c))
					step_bytes.push_back(upcase(c));
				else
					classify_plain(c, req.in_last);
			end
			MODE_BIN: begin
				if (c == CH_ZERO || c == CH_ONE)
					step_bytes.push_back(c);
				else
					classify_plain(c, req.in_last);
			end
			default: begin
				classify_plain(c, req.in_last);
			end
		endcase
		// Every expression starts afresh in the normal mode.
		if (req.in_last)
			scan_state = MODE_NORMAL;
		foreach (step_bytes[i]) begin
			res.out_char = step_bytes[i];
			res.out_run_last = (i == step_bytes.size() - 1);
			res.out_expr_end = res.out_run_last && req.in_last;
			expected_norm.push_back(res);
		end
	endtask

	task automatic push_request(input logic [7:0] c, input bit last, input bit hold);
		text_entry_t entry;
		entry.req.in_char = c;
		entry.req.in_last = last;
		entry.hold_for_drain = hold;
		pending_text.push_back(entry);
	endtask

	task automatic queue_text(input string s, input bit hold);
		for (int i = 0; i < s.len(); i++)
			push_request(s[i], i == s.len() - 1, hold && i == 0);
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? "a" : "A";
		return base + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_hex_digit();
		case ($urandom_range(0, 2))
			0: return CH_ZERO + 8'($urandom_range(0, 9));
			1: return "a" + 8'($urandom_range(0, 5));
			default: return "A" + 8'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [7:0] random_word_char();
		case ($urandom_range(0, 5))
			0: return CH_UNDER;
			1: return CH_DOT;
			2: return CH_ZERO + 8'($urandom_range(0, 9));
			default: return random_letter();
		endcase
	endfunction

	// Appends one token of assembler text to expr_buf. Tokens run into each other without
	// separators now and then, so that every scan gets ended by every sort of byte.
	task automatic add_token();
		string ops;
		int len;
		ops = "+-*/()<>,#=&|^!~ ";
		len = $urandom_range(1, 5);
		case ($urandom_range(0, 15))
			0, 1, 2: begin
				case ($urandom_range(0, 3))
					0: expr_buf.push_back(CH_UNDER);
					1: expr_buf.push_back(CH_DOT);
					default: expr_buf.push_back(random_letter());
				endcase
				repeat (len) expr_buf.push_back(random_word_char());
			end
			3: begin
				expr_buf.push_back(CH_DOLLAR);
				repeat (len) expr_buf.push_back(random_hex_digit());
			end
			4: begin
				expr_buf.push_back(CH_ZERO);
				expr_buf.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
				repeat (len) expr_buf.push_back(random_hex_digit());
			end
			5: begin
				expr_buf.push_back(CH_PERCENT);
				repeat (len) expr_buf.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
			end
			6: begin
				expr_buf.push_back(CH_ZERO);
				expr_buf.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
				repeat (len) expr_buf.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
			end
			7, 8: begin
				repeat (len) begin
					if ($urandom_range(0, 2) == 0)
						expr_buf.push_back(CH_ZERO);
					else
						expr_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
			end
			9, 10: expr_buf.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			11, 12: expr_buf.push_back(CH_ZERO);
			13: expr_buf.push_back(8'($urandom_range(0, 255)));
			14: begin
				expr_buf.push_back(CH_ZERO);
				expr_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end
			default: expr_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
		endcase
	endtask

	task automatic queue_expression(input bit hold);
		expr_buf.delete();
		repeat ($urandom_range(1, 6)) add_token();
		foreach (expr_buf[i])
			push_request(expr_buf[i], i == expr_buf.size() - 1, hold && i == 0);
	endtask

	// Driver. A request stays on text_data until it is taken; after each one the sender waits
	// a drawn number of cycles, except in quiet stretches where it streams back to back.
	int send_gap = 0;
	bit send_quiet = 1'b0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall)
				predict_request(text_data);
			if (!text_valid || !text_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					text_valid <= 1'b0;
				end else if (pending_text.size() == 0) begin
					text_valid <= 1'b0;
				end else if (pending_text[0].hold_for_drain && expected_norm.size() != 0) begin
					text_valid <= 1'b0;
				end else begin
					text_data <= pending_text[0].req;
					text_valid <= 1'b1;
					void'(pending_text.pop_front());
					if ($urandom_range(0, 63) == 0)
						send_quiet = !send_quiet;
					send_gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
				end
			end
		end
	end

	// Monitor. Each normalised byte taken is checked against the oldest expectation, and the
	// receiver then stalls for a drawn number of cycles, again with quiet stretches.
	int recv_stall = 0;
	bit recv_quiet = 1'b0;
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (norm_valid && !norm_stall) begin
				if (expected_norm.size() == 0) begin
					report_mismatch($sformatf("unexpected result byte %h", norm_data.out_char));
				end else begin
					want = expected_norm.pop_front();
					if (norm_data.out_char !== want.out_char)
						report_mismatch($sformatf("out_char %h, expected %h",
							norm_data.out_char, want.out_char));
					if (norm_data.out_run_last !== want.out_run_last)
						report_mismatch($sformatf("out_run_last %b, expected %b",
							norm_data.out_run_last, want.out_run_last));
					if (norm_data.out_expr_end !== want.out_expr_end)
						report_mismatch($sformatf("out_expr_end %b, expected %b",
							norm_data.out_expr_end, want.out_expr_end));
				end
				if ($urandom_range(0, 63) == 0)
					recv_quiet = !recv_quiet;
				recv_stall = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				norm_stall <= 1'b1;
			end else begin
				norm_stall <= 1'b0;
			end
		end
	end

	initial begin
		// Directed part: both prefix forms of each literal kind, literals cut short by bytes of
		// another class, a held '0' flushed by another '0' and by the last byte, a lone '0' closing
		// an expression, and bytes outside the ASCII classes.
		queue_text("0X1f", 1'b0);
		queue_text("0b12", 1'b0);
		queue_text("%10$g", 1'b0);
		queue_text("00", 1'b0);
		push_request(8'h00, 1'b0, 1'b0);
		push_request(8'hFF, 1'b0, 1'b0);
		push_request(8'h80, 1'b1, 1'b0);
		queue_text("0B", 1'b0);
		queue_text("0", 1'b0);
		queue_text("._9", 1'b0);

		// Random part: whole expressions, the first of which waits until the directed part
		// has drained completely. Further drains are scattered through the run.
		queue_expression(1'b1);
		while (pending_text.size() < RANDOM_REQUESTS + 24)
			queue_expression($urandom_range(0, 29) == 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Sampling on the falling edge keeps this wait clear of the driver's updates.
		while (pending_text.size() != 0 || text_valid || expected_norm.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/asm_norm_pkg.sv
rtl/core/asm_norm_decode.sv
rtl/core/asm_expression_normalizer_top.sv
test/testbench.sv
